// ----- src/ipv4_host_port_parser_assert.svh -----
// Assertion macros for the IPv4 host:port parser.
// Taken in by `include in the modules that check their own logic.
`ifndef IPV4_HOST_PORT_PARSER_ASSERT_SVH
`define IPV4_HOST_PORT_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset
`define IHPP_ASSERT_IMPLY(lbl, clock, reset, ante, cons) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("ihpp assertion failed");
// Next-cycle implication, checked out of reset
`define IHPP_ASSERT_NEXT(lbl, clock, reset, ante, cons) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("ihpp assertion failed");
`else
`define IHPP_ASSERT_IMPLY(lbl, clock, reset, ante, cons)
`define IHPP_ASSERT_NEXT(lbl, clock, reset, ante, cons)
`endif

`endif

// ----- src/ihpp_pkg.sv -----
// Package for the IPv4 host:port parser: transfer types, status codes,
// character codes and limits. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ihpp_pkg;

  // Width of the byte offset counter
  localparam int unsigned POS_W = 8;
  localparam logic [POS_W-1:0] POS_LIMIT = {POS_W{1'b1}};

  // Status codes as seen on the result
  localparam logic [2:0] STAT_WAIT   = 3'd0;
  localparam logic [2:0] STAT_OCTETS = 3'd1;
  localparam logic [2:0] STAT_COLON  = 3'd2;
  localparam logic [2:0] STAT_PORT   = 3'd3;
  localparam logic [2:0] STAT_TRAIL  = 3'd4;
  localparam logic [2:0] STAT_CR     = 3'd5;
  localparam logic [2:0] STAT_DONE   = 3'd6;
  localparam logic [2:0] STAT_ERROR  = 3'd7;

  // Limits
  localparam logic [11:0] OCTET_MAX   = 12'd255;
  localparam logic [19:0] PORT_MAX    = 20'd65535;
  localparam logic [1:0]  DOTS_NEEDED = 2'd3;

  // ASCII codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  parse_status;
    logic [7:0]  host_start;
    logic [7:0]  host_end;
    logic [15:0] port_value;
    logic        done_res;
    logic        failed;
  } out_item_t;

  // Byte offset clamped to 8 bits
  function automatic logic [7:0] sat8(input logic [POS_W-1:0] pos);
    logic [POS_W+7:0] ext;
    ext = {8'b0, pos};
    return (ext > (POS_W+8)'(255)) ? 8'hFF : ext[7:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/ihpp_in_stage.sv -----
// Input register of the IPv4 host:port parser.
// Holds one request transfer until the parser step takes it; uses ihpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ihpp_in_stage
  import ihpp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_stall,
  input  wire in_item_t req,
  input  wire logic     advance,
  output logic          held_valid,
  output in_item_t      held
);

  // Stall only while a held byte cannot move on
  assign req_stall = held_valid & ~advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!req_stall) begin
      held_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      held <= req;
    end
  end

endmodule

`default_nettype wire

// ----- src/ihpp_fsm.sv -----
// Parser state and per-byte update for the IPv4 host:port parser.
// State advances once per byte handed on; uses ihpp_pkg and the assert macros.
`timescale 1ns / 1ps
`default_nettype none

`include "ipv4_host_port_parser_assert.svh"

module ihpp_fsm
  import ihpp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     advance,
  input  wire in_item_t item,
  output out_item_t     result
);

  typedef enum logic [2:0] {
    ST_WAIT   = STAT_WAIT,
    ST_OCTETS = STAT_OCTETS,
    ST_COLON  = STAT_COLON,
    ST_PORT   = STAT_PORT,
    ST_TRAIL  = STAT_TRAIL,
    ST_CR     = STAT_CR,
    ST_DONE   = STAT_DONE,
    ST_ERROR  = STAT_ERROR
  } state_t;

  state_t           state, state_next;
  logic [7:0]       octet_value, octet_value_next;
  logic [1:0]       dot_count, dot_count_next;
  logic [15:0]      port_accum, port_accum_next;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [7:0]       start_offset, start_offset_next;
  logic [7:0]       end_offset, end_offset_next;

  // Values the byte works on: restart clears them first
  state_t           b_state;
  logic [7:0]       b_octet;
  logic [1:0]       b_dots;
  logic [15:0]      b_port;
  logic [POS_W-1:0] b_pos;
  logic [7:0]       b_start;
  logic [7:0]       b_end;

  logic [7:0]  c;
  logic [7:0]  c_off;
  logic [3:0]  digit;
  logic        is_digit;
  logic        active;
  logic [11:0] octet_ext, octet_sum;
  logic [19:0] port_ext, port_sum;

  always_comb begin
    if (item.restart) begin
      b_state = ST_WAIT;
      b_octet = '0;
      b_dots  = '0;
      b_port  = '0;
      b_pos   = '0;
      b_start = '0;
      b_end   = '0;
    end else begin
      b_state = state;
      b_octet = octet_value;
      b_dots  = dot_count;
      b_port  = port_accum;
      b_pos   = byte_position;
      b_start = start_offset;
      b_end   = end_offset;
    end
  end

  // Digit decode and decimal accumulate (x*10 as two shifts)
  assign c         = item.byte_value;
  assign c_off     = c - CH_ZERO;
  assign digit     = c_off[3:0];
  assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
  assign octet_ext = {4'b0, b_octet};
  assign octet_sum = (octet_ext << 3) + (octet_ext << 1) + {8'b0, digit};
  assign port_ext  = {4'b0, b_port};
  assign port_sum  = (port_ext << 3) + (port_ext << 1) + {16'b0, digit};
  assign active    = (b_state != ST_DONE) && (b_state != ST_ERROR);

  // Per-byte state update
  always_comb begin
    state_next         = b_state;
    octet_value_next   = b_octet;
    dot_count_next     = b_dots;
    port_accum_next    = b_port;
    byte_position_next = b_pos;
    start_offset_next  = b_start;
    end_offset_next    = b_end;
    if (active) begin
      unique case (b_state)
        ST_WAIT: begin
          if (c == CH_SPACE) begin
            state_next = ST_WAIT;
          end else if (is_digit) begin
            state_next        = ST_OCTETS;
            start_offset_next = sat8(b_pos);
            octet_value_next  = {4'b0, digit};
          end else begin
            state_next = ST_ERROR;
          end
        end
        ST_OCTETS: begin
          if (is_digit) begin
            if (octet_sum > OCTET_MAX) begin
              state_next = ST_ERROR;
            end else begin
              octet_value_next = octet_sum[7:0];
            end
          end else if (c == CH_DOT && b_dots != DOTS_NEEDED) begin
            dot_count_next   = b_dots + 2'd1;
            octet_value_next = '0;
          end else if (c == CH_COLON && b_dots == DOTS_NEEDED) begin
            end_offset_next = sat8(b_pos);
            state_next      = ST_COLON;
          end else begin
            state_next = ST_ERROR;
          end
        end
        ST_COLON: begin
          if (is_digit) begin
            port_accum_next = {12'b0, digit};
            state_next      = ST_PORT;
          end else begin
            state_next = ST_ERROR;
          end
        end
        ST_PORT: begin
          // other characters inside the port are skipped
          if (is_digit) begin
            if (port_sum > PORT_MAX) begin
              state_next = ST_ERROR;
            end else begin
              port_accum_next = port_sum[15:0];
            end
          end else if (c == CH_SPACE) begin
            state_next = ST_TRAIL;
          end else if (c == CH_CR) begin
            state_next = ST_CR;
          end
        end
        ST_TRAIL: begin
          if (c == CH_SPACE) begin
            state_next = ST_TRAIL;
          end else if (c == CH_CR) begin
            state_next = ST_CR;
          end else begin
            state_next = ST_ERROR;
          end
        end
        ST_CR: begin
          state_next = (c == CH_LF) ? ST_DONE : ST_ERROR;
        end
        default: begin
          state_next = ST_ERROR;
        end
      endcase
      if (b_pos != POS_LIMIT) begin
        byte_position_next = b_pos + POS_W'(1);
      end
    end
  end

  // State registers, updated once per byte handed on
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_WAIT;
      octet_value   <= '0;
      dot_count     <= '0;
      port_accum    <= '0;
      byte_position <= '0;
      start_offset  <= '0;
      end_offset    <= '0;
    end else if (advance) begin
      state         <= state_next;
      octet_value   <= octet_value_next;
      dot_count     <= dot_count_next;
      port_accum    <= port_accum_next;
      byte_position <= byte_position_next;
      start_offset  <= start_offset_next;
      end_offset    <= end_offset_next;
    end
  end

  // Result reflects the state after this byte
  always_comb begin
    result.parse_status = state_next;
    result.host_start   = start_offset_next;
    result.host_end     = end_offset_next;
    result.port_value   = port_accum_next;
    result.done_res     = (state_next == ST_DONE);
    result.failed       = (state_next == ST_ERROR);
  end

  // Once finished, bytes without restart leave the offset alone
  `IHPP_ASSERT_NEXT(a_hold_pos, clk, rst, advance && !item.restart && (state == ST_DONE || state == ST_ERROR), $stable(byte_position))
  // Restart always lands in one of the first-byte outcomes
  `IHPP_ASSERT_NEXT(a_restart, clk, rst, advance && item.restart, state == ST_WAIT || state == ST_OCTETS || state == ST_ERROR)
  // The port is only ever reached after all three dots
  `IHPP_ASSERT_IMPLY(a_dots, clk, rst, state == ST_COLON || state == ST_PORT || state == ST_TRAIL || state == ST_CR, dot_count == DOTS_NEEDED)

endmodule

`default_nettype wire

// ----- src/ipv4_host_port_parser.sv -----
// Takes Host header value bytes one per cycle while no stall holds them, checks
// a.b.c.d:port CR LF and reports status, host offsets and port for every byte.
// The block accepts a byte in every cycle unless stalled and returns one result
// per byte: the input register takes the byte, then the state update loads the
// result register, from which the result can leave. Stalls on the result side
// back up through the input register without loss. No memories; nothing to
// clear after reset.
// Depends on ihpp_pkg, ihpp_in_stage, ihpp_fsm and the assert macros.
`timescale 1ns / 1ps
`default_nettype none

`include "ipv4_host_port_parser_assert.svh"

module ipv4_host_port_parser
  import ihpp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_stall,
  input  wire in_item_t req,
  output logic          res_valid,
  input  wire logic     res_stall,
  output out_item_t     res
);

  logic      held_valid;
  in_item_t  held;
  logic      advance;
  out_item_t result;

  // A held byte moves on when the result register is free or draining
  assign advance = held_valid & (~res_valid | ~res_stall);

  ihpp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .advance    (advance),
    .held_valid (held_valid),
    .held       (held)
  );

  ihpp_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (held),
    .result  (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= result;
    end
  end

  `IHPP_ASSERT_IMPLY(a_excl, clk, rst, res_valid, !(res.done_res && res.failed))
  `IHPP_ASSERT_IMPLY(a_done, clk, rst, res_valid, res.done_res == (res.parse_status == STAT_DONE))
  `IHPP_ASSERT_IMPLY(a_fail, clk, rst, res_valid, res.failed == (res.parse_status == STAT_ERROR))

endmodule

`default_nettype wire
